// File: design/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants for the segment chain follower.
// ----------------------------------------------------------------------------
package scf_pkg;

	localparam int COORD_W = 16;
	localparam int LEN_W   = 12;
	localparam int ACT_W   = 4;

	localparam logic [LEN_W-1:0] LEN_RESET = 12'd48;
	localparam logic [ACT_W-1:0] ACT_RESET = 4'd2;
	localparam logic [3:0]       BIT_TOP   = 4'd11;

	// register indexes of the configuration port
	localparam logic [0:0] REG_SEG_LEN = 1'b0;
	localparam logic [0:0] REG_ACTIVE  = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] target_x;
		logic signed [COORD_W-1:0] target_y;
	} in_t;

	typedef struct packed {
		logic [2:0]                segment_index;
		logic signed [COORD_W-1:0] joint_x_out;
		logic signed [COORD_W-1:0] joint_y_out;
		logic                      last_joint;
	} out_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TGT,
		OP_RD,
		OP_LDP,
		OP_LDF,
		OP_MUL_AX,
		OP_MUL_AY,
		OP_MUL_LL,
		OP_SUM,
		OP_MUL_LHS,
		OP_LHS_SV,
		OP_PR_SQ,
		OP_PR_MS,
		OP_PR_CMP,
		OP_WR,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       comp;
		logic [3:0] bit_idx;
		logic [2:0] seg;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic out_free;
	} dp_stat_t;

endpackage

// File: design/scf_dp.sv
// ----------------------------------------------------------------------------
// scf_dp
// Datapath: joint store, shared multiplier, bitwise search of the scaled
// offset, saturating update and the output register.
// ----------------------------------------------------------------------------
module scf_dp import scf_pkg::*; #(
	parameter int NUM_SEGMENTS = 8,
	localparam int AW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_idx,
	input  logic [LEN_W-1:0]    cfg_wdata,
	input  in_t                 in_data,
	input  dp_cmd_t             cmd,
	input  logic [AW-1:0]       addr,
	output dp_stat_t            stat,
	output logic                out_valid,
	input  logic                out_ready,
	output out_t                out_data
);

	logic [2*COORD_W-1:0] mem [NUM_SEGMENTS];
	logic [NUM_SEGMENTS-1:0] vld_q;
	logic [2*COORD_W-1:0] rd_q;

	logic [LEN_W-1:0] len_q;
	logic signed [COORD_W-1:0] f_x_q, f_y_q, p_x_q, p_y_q;
	logic dx_neg_q, dy_neg_q, zero_q;
	logic [COORD_W-1:0] ax_q, ay_q;
	logic [31:0] sqx_q, sqy_q;
	logic [32:0] s_q;
	logic [23:0] l2_q;
	logic [58:0] lhs_q;
	logic [LEN_W-1:0] q_q, qx_q;
	logic [61:0] prod_q;
	logic out_valid_q;
	out_t out_q;

	logic signed [COORD_W:0] dx, dy;
	logic [33:0] mul_a;
	logic [27:0] mul_b;
	logic [LEN_W-1:0] cand;
	logic [LEN_W:0] tval;
	logic signed [COORD_W-1:0] new_x, new_y;

	function automatic logic [2*COORD_W-1:0] rst_val(input logic [AW-1:0] a);
		logic signed [31:0] x;
		x = 32'sd5120 - 32'sd48 * $signed({1'b0, 31'(a)});
		return {16'(x), 16'sd5120};
	endfunction

	function automatic logic signed [COORD_W-1:0] move(
		input logic signed [COORD_W-1:0] f,
		input logic neg,
		input logic [LEN_W-1:0] q
	);
		logic signed [COORD_W+1:0] r;
		r = neg ? ({{2{f[COORD_W-1]}}, f} - $signed({6'b0, q}))
		        : ({{2{f[COORD_W-1]}}, f} + $signed({6'b0, q}));
		if (r > 18'sd32767)
			return 16'sh7FFF;
		else if (r < -18'sd32768)
			return 16'sh8000;
		else
			return 16'(r);
	endfunction

	assign dx = $signed({rd_q[31], rd_q[31:16]}) - $signed({f_x_q[15], f_x_q});
	assign dy = $signed({rd_q[15], rd_q[15:0]}) - $signed({f_y_q[15], f_y_q});
	assign cand = q_q | (12'd1 << cmd.bit_idx);
	assign tval = {cand, 1'b0} - 13'd1;
	assign new_x = zero_q ? p_x_q : move(f_x_q, dx_neg_q, qx_q);
	assign new_y = zero_q ? p_y_q : move(f_y_q, dy_neg_q, q_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_AX: begin mul_a = 34'(ax_q); mul_b = 28'(ax_q); end
			OP_MUL_AY: begin mul_a = 34'(ay_q); mul_b = 28'(ay_q); end
			OP_MUL_LL: begin mul_a = 34'(len_q); mul_b = 28'(len_q); end
			OP_MUL_LHS: begin
				mul_a = 34'(cmd.comp ? sqy_q : sqx_q);
				mul_b = 28'(l2_q);
			end
			OP_PR_SQ: begin mul_a = 34'(tval); mul_b = 28'(tval); end
			OP_PR_MS: begin mul_a = 34'(s_q); mul_b = 28'(prod_q[25:0]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// joint store: one read, one write port
	always_ff @(posedge clk) begin
		if (cmd.op == OP_RD)
			rd_q <= vld_q[addr] ? mem[addr] : rst_val(addr);
		if (cmd.op == OP_WR)
			mem[addr] <= {new_x, new_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			len_q       <= LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_WR)
				vld_q[addr] <= 1'b1;
			if (cfg_we && cfg_idx == REG_SEG_LEN)
				len_q <= cfg_wdata;
			if (cmd.op == OP_EMIT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 62'(mul_a * mul_b);
		case (cmd.op)
			OP_TGT: begin
				f_x_q <= in_data.target_x;
				f_y_q <= in_data.target_y;
			end
			OP_LDF: begin
				f_x_q <= rd_q[31:16];
				f_y_q <= rd_q[15:0];
			end
			OP_LDP: begin
				p_x_q    <= rd_q[31:16];
				p_y_q    <= rd_q[15:0];
				dx_neg_q <= dx[COORD_W];
				dy_neg_q <= dy[COORD_W];
				ax_q     <= 16'(dx[COORD_W] ? -dx : dx);
				ay_q     <= 16'(dy[COORD_W] ? -dy : dy);
				zero_q   <= (dx == '0) && (dy == '0);
			end
			OP_MUL_AY: sqx_q <= prod_q[31:0];
			OP_MUL_LL: sqy_q <= prod_q[31:0];
			OP_SUM: begin
				l2_q <= prod_q[23:0];
				s_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
			end
			OP_LHS_SV: begin
				lhs_q <= {prod_q[56:0], 2'b00};
				q_q   <= '0;
				if (cmd.comp)
					qx_q <= q_q;
			end
			OP_PR_CMP: begin
				if (cand <= len_q && prod_q <= {3'b0, lhs_q})
					q_q <= cand;
			end
			OP_EMIT: begin
				out_q.segment_index <= cmd.seg;
				out_q.joint_x_out   <= rd_q[31:16];
				out_q.joint_y_out   <= rd_q[15:0];
				out_q.last_joint    <= cmd.last;
			end
			default: ;
		endcase
	end

	assign stat.zero     = zero_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

// File: design/scf_ctrl.sv
// ----------------------------------------------------------------------------
// scf_ctrl
// Sequencer: walks the joints, the two components and the search bits, then
// reads the chain back out.
// ----------------------------------------------------------------------------
module scf_ctrl import scf_pkg::*; #(
	parameter int NUM_SEGMENTS = 8,
	localparam int AW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_idx,
	input  logic [ACT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	output dp_cmd_t          cmd,
	output logic [AW-1:0]    addr,
	input  dp_stat_t         stat
);

	localparam logic [ACT_W-1:0] CAP = ACT_W'((NUM_SEGMENTS < 8) ? NUM_SEGMENTS : 8);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_P, ST_LD_P, ST_CHK, ST_MUL_Y, ST_MUL_L, ST_SUM, ST_LHS,
		ST_LHS_SV, ST_PR_SQ, ST_PR_MS, ST_PR_CMP, ST_WR, ST_RD_F, ST_LD_F, ST_EM
	} state_t;

	state_t state_q;
	logic [ACT_W-1:0] active_q, n_q, n_clamp;
	logic [AW-1:0] idx_q;
	logic tail_q, comp_q, em_rd_q;
	logic [3:0] bit_q;
	logic is_last, is_pen;

	assign n_clamp = (active_q < 4'd2) ? 4'd2 : ((active_q > CAP) ? CAP : active_q);
	assign is_last = (32'(idx_q) == 32'(n_q) - 32'd1);
	assign is_pen  = (32'(idx_q) == 32'(n_q) - 32'd2);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= ACT_RESET;
			n_q      <= ACT_RESET;
			idx_q    <= '0;
			tail_q   <= 1'b0;
			comp_q   <= 1'b0;
			bit_q    <= '0;
			em_rd_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == REG_ACTIVE)
				active_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					n_q     <= n_clamp;
					idx_q   <= AW'(n_clamp - 4'd1);
					tail_q  <= 1'b1;
					state_q <= ST_RD_P;
				end
				ST_RD_P:  state_q <= ST_LD_P;
				ST_LD_P:  state_q <= ST_CHK;
				ST_CHK:   state_q <= stat.zero ? ST_WR : ST_MUL_Y;
				ST_MUL_Y: state_q <= ST_MUL_L;
				ST_MUL_L: state_q <= ST_SUM;
				ST_SUM: begin
					comp_q  <= 1'b0;
					state_q <= ST_LHS;
				end
				ST_LHS: state_q <= ST_LHS_SV;
				ST_LHS_SV: begin
					bit_q   <= BIT_TOP;
					state_q <= ST_PR_SQ;
				end
				ST_PR_SQ: state_q <= ST_PR_MS;
				ST_PR_MS: state_q <= ST_PR_CMP;
				ST_PR_CMP: begin
					if (bit_q != 4'd0) begin
						bit_q   <= bit_q - 4'd1;
						state_q <= ST_PR_SQ;
					end else if (!comp_q) begin
						comp_q  <= 1'b1;
						state_q <= ST_LHS;
					end else begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (tail_q) begin
						tail_q  <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_RD_F;
					end else if (is_pen) begin
						idx_q   <= '0;
						em_rd_q <= 1'b1;
						state_q <= ST_EM;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD_F;
					end
				end
				ST_RD_F: state_q <= ST_LD_F;
				ST_LD_F: state_q <= ST_RD_P;
				ST_EM: begin
					if (em_rd_q)
						em_rd_q <= 1'b0;
					else if (stat.out_free) begin
						if (is_last)
							state_q <= ST_IDLE;
						else begin
							idx_q   <= idx_q + 1'b1;
							em_rd_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_NONE;
		cmd.comp    = comp_q;
		cmd.bit_idx = bit_q;
		cmd.seg     = 3'(idx_q);
		cmd.last    = is_last;
		addr        = idx_q;
		case (state_q)
			ST_IDLE:   cmd.op = in_valid ? OP_TGT : OP_NONE;
			ST_RD_P:   cmd.op = OP_RD;
			ST_LD_P:   cmd.op = OP_LDP;
			ST_CHK:    cmd.op = OP_MUL_AX;
			ST_MUL_Y:  cmd.op = OP_MUL_AY;
			ST_MUL_L:  cmd.op = OP_MUL_LL;
			ST_SUM:    cmd.op = OP_SUM;
			ST_LHS:    cmd.op = OP_MUL_LHS;
			ST_LHS_SV: cmd.op = OP_LHS_SV;
			ST_PR_SQ:  cmd.op = OP_PR_SQ;
			ST_PR_MS:  cmd.op = OP_PR_MS;
			ST_PR_CMP: cmd.op = OP_PR_CMP;
			ST_WR:     cmd.op = OP_WR;
			ST_RD_F: begin
				cmd.op = OP_RD;
				addr   = idx_q + 1'b1;
			end
			ST_LD_F:   cmd.op = OP_LDF;
			ST_EM:     cmd.op = em_rd_q ? OP_RD : (stat.out_free ? OP_EMIT : OP_NONE);
			default:   cmd.op = OP_NONE;
		endcase
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> stat.out_free) else $error("emit into full output");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> 32'(idx_q) < 32'(n_q)) else $error("joint index beyond chain");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q >= 4'd2 && n_q <= CAP) else $error("chain length out of range");

endmodule

// File: design/segment_chain_follow.sv
// ----------------------------------------------------------------------------
// segment_chain_follow
// Follow-the-leader chain: each target transfer drags the chain end towards it and
// every other joint towards its successor, then all joints are sent out.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_we/cfg_idx/cfg_wdata write segment length (index 0, Q8.4) and the
//    number of segments in use (index 1, clamped to 2..min(NUM_SEGMENTS,8)).
//    Write only while idle.
//  - in channel: one target point per transfer; taken only when idle.
//  - out channel: one transfer per active joint, index 0 first, last_joint
//    high on the final one.
//  - Timing: each joint runs two 12-step searches, one per component, on the
//    one shared multiplier; a joint that already sits on the point it follows
//    skips both searches. Read-out reads each joint, then sends it.
//  - A receiver stall holds the block in read-out; the output register keeps
//    the pending transfer stable.
//  - Reset: joints return to their home line (x = 320 - 3i, y = 320) through
//    per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module segment_chain_follow import scf_pkg::*; #(
	parameter int NUM_SEGMENTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_idx,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data
);

	localparam int AW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] addr;

	// sequencer
	scf_ctrl #(.NUM_SEGMENTS(NUM_SEGMENTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata[ACT_W-1:0]),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.addr      (addr),
		.stat      (stat)
	);

	// joint store, arithmetic and output register
	scf_dp #(.NUM_SEGMENTS(NUM_SEGMENTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.addr      (addr),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
